>>> src/lmwq_pkg.sv
// lmwq_pkg: sizes, codes and the lock table entry type for the lock manager
// no dependencies
package lmwq_pkg;

  localparam int NUM_LOCKS   = 64;
  localparam int WAIT_DEPTH  = 8;
  localparam int CLIENT_BITS = 8;

  localparam int LOCK_AW = $clog2(NUM_LOCKS);
  localparam int WAIT_AW = $clog2(WAIT_DEPTH);
  localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] MODE_FREE   = 2'd0;
  localparam logic [1:0] MODE_LOCKED = 2'd1;
  localparam logic [1:0] MODE_WAITED = 2'd2;
  localparam logic [1:0] MODE_RETRY  = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RETRY = 3'd1;
  localparam logic [2:0] ST_NOENT = 3'd2;
  localparam logic [2:0] ST_IOERR = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef logic [CLIENT_BITS-1:0] client_t;
  typedef logic [LOCK_AW-1:0]     lock_idx_t;
  typedef logic [WAIT_AW-1:0]     wait_ptr_t;
  typedef logic [CNT_W-1:0]       wait_cnt_t;

  typedef struct packed {
    client_t   owner;
    logic [1:0] mode;
    wait_ptr_t head;
    wait_cnt_t count;
  } lock_word_t;

endpackage

>>> src/lock_manager_with_waiter_queues.sv
// lock_manager_with_waiter_queues: lock table with per-lock waiter fifos
// depends on lmwq_pkg
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-------------------------
//  request  | req_valid req_ready cmd lock_id requester | acquire or release
//  response | rsp_valid rsp_ready status send_revoke    | one per request
//           | send_retry notify_client                  |
//
// a request is handled in order: the lock table entry is read, then the head
// waiter slot of that lock, then the entry and queue are updated
// the next request is taken in the cycle the previous one is written back,
// with the written entry forwarded to it
// reset clears the per-lock valid bits and the control flags, not the memories; no clearing pass is needed
// a held response stalls write-back and so the request side
module lock_manager_with_waiter_queues (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       cmd,
  input  logic [5:0] lock_id,
  input  logic [7:0] requester,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [2:0] status,
  output logic       send_revoke,
  output logic       send_retry,
  output logic [7:0] notify_client
);
  import lmwq_pkg::*;

  lock_word_t lock_mem [NUM_LOCKS];
  client_t    waiter_store [NUM_LOCKS][WAIT_DEPTH];
  logic [NUM_LOCKS-1:0] lock_valid;

  logic busy_a, busy_b;
  logic accept, finishing;

  logic       cmd_a, cmd_b;
  lock_idx_t  lk_a, lk_b;
  logic       range_a, range_b;
  client_t    who_a, who_b;
  lock_word_t word_a, word_b;
  client_t    head_client;

  lock_idx_t  lk_in;
  logic       range_in;
  wait_ptr_t  head_a;

  logic       valid_b, full, is_head, wr, wq;
  logic [1:0] mode_b;
  wait_ptr_t  head_b, head_inc, slot;
  wait_cnt_t  count_b;
  logic [WAIT_AW:0] slot_sum;
  lock_word_t word_next;
  logic [2:0] st_next;
  logic       rev_next, rty_next;
  client_t    tgt_next;

  assign lk_in    = LOCK_AW'(lock_id);
  assign range_in = 32'(lock_id) < NUM_LOCKS;

  assign finishing = busy_b && (!rsp_valid || rsp_ready);
  assign req_ready = !busy_a && (!busy_b || finishing);
  assign accept    = req_valid && req_ready;

  assign head_a = lock_valid[lk_a] ? word_a.head : '0;

  always_comb begin
    valid_b  = lock_valid[lk_b];
    mode_b   = valid_b ? word_b.mode : MODE_FREE;
    head_b   = valid_b ? word_b.head : '0;
    count_b  = valid_b ? word_b.count : '0;
    full     = count_b >= CNT_W'(WAIT_DEPTH);
    is_head  = (mode_b == MODE_RETRY) && (count_b != '0) && (head_client == who_b);
    slot_sum = {1'b0, head_b} + (WAIT_AW + 1)'(count_b);
    if (slot_sum >= (WAIT_AW + 1)'(WAIT_DEPTH)) begin
      slot = WAIT_AW'(slot_sum - (WAIT_AW + 1)'(WAIT_DEPTH));
    end else begin
      slot = WAIT_AW'(slot_sum);
    end
    if (head_b == WAIT_AW'(WAIT_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_b + 1'b1;
    end

    word_next = '{owner: word_b.owner, mode: mode_b, head: head_b, count: count_b};
    st_next   = ST_OK;
    rev_next  = 1'b0;
    rty_next  = 1'b0;
    tgt_next  = '0;
    wr        = 1'b0;
    wq        = 1'b0;

    if (!range_b) begin
      st_next = ST_NOENT;
    end else if (cmd_b == CMD_ACQUIRE) begin
      if (mode_b != MODE_FREE && !is_head && full) begin
        st_next = ST_FULL;
      end else begin
        wr = 1'b1;
        case (mode_b)
          MODE_FREE: begin
            word_next.owner = who_b;
            word_next.mode  = MODE_LOCKED;
          end
          MODE_LOCKED: begin
            wq              = 1'b1;
            word_next.count = count_b + 1'b1;
            word_next.mode  = MODE_WAITED;
            st_next         = ST_RETRY;
            rev_next        = 1'b1;
            tgt_next        = word_b.owner;
          end
          MODE_WAITED: begin
            wq              = 1'b1;
            word_next.count = count_b + 1'b1;
            st_next         = ST_RETRY;
          end
          default: begin
            if (is_head) begin
              word_next.head  = head_inc;
              word_next.count = count_b - 1'b1;
              word_next.owner = who_b;
              if (count_b > CNT_W'(1)) begin
                word_next.mode = MODE_WAITED;
                rev_next       = 1'b1;
                tgt_next       = who_b;
              end else begin
                word_next.mode = MODE_LOCKED;
              end
            end else begin
              wq              = 1'b1;
              word_next.count = count_b + 1'b1;
              st_next         = ST_RETRY;
            end
          end
        endcase
      end
    end else begin
      if (!valid_b) begin
        st_next = ST_NOENT;
      end else begin
        case (mode_b)
          MODE_LOCKED: begin
            wr             = 1'b1;
            word_next.mode = MODE_FREE;
          end
          MODE_WAITED: begin
            wr             = 1'b1;
            word_next.mode = MODE_RETRY;
            rty_next       = 1'b1;
            tgt_next       = head_client;
          end
          default: begin
            st_next = ST_IOERR;
          end
        endcase
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_a     <= 1'b0;
      busy_b     <= 1'b0;
      rsp_valid  <= 1'b0;
      lock_valid <= '0;
    end else begin
      busy_a <= accept;
      busy_b <= busy_a || (busy_b && !finishing);
      if (finishing) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (finishing && wr) begin
        lock_valid[lk_b] <= 1'b1;
      end
    end
  end

  // lock table and waiter memories
  always_ff @(posedge clk) begin
    if (finishing && wr) begin
      lock_mem[lk_b] <= word_next;
    end
    if (finishing && wq) begin
      waiter_store[lk_b][slot] <= who_b;
    end
    if (accept) begin
      if (finishing && wr && lk_b == lk_in) begin
        word_a <= word_next;
      end else begin
        word_a <= lock_mem[lk_in];
      end
    end
    if (busy_a) begin
      head_client <= waiter_store[lk_a][head_a];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_a   <= cmd;
      lk_a    <= lk_in;
      range_a <= range_in;
      who_a   <= CLIENT_BITS'(requester);
    end
    if (busy_a) begin
      cmd_b   <= cmd_a;
      lk_b    <= lk_a;
      range_b <= range_a;
      who_b   <= who_a;
      word_b  <= word_a;
    end
    if (finishing) begin
      status        <= st_next;
      send_revoke   <= rev_next;
      send_retry    <= rty_next;
      notify_client <= 8'(tgt_next);
    end
  end

endmodule

>>> bench/tb_lock_manager_with_waiter_queues.sv
`timescale 1ns / 100ps
// tb_lock_manager_with_waiter_queues: directed and random acquire/release traffic
// against a lock table predictor, responses checked field by field in order
// depends on lmwq_pkg and lock_manager_with_waiter_queues
module tb_lock_manager_with_waiter_queues;
  import lmwq_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1826;

  typedef struct packed {
    logic [2:0] status;
    logic       revoke;
    logic       retry;
    client_t    notify;
  } lock_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  logic       cmd = CMD_ACQUIRE;
  logic [5:0] lock_id = '0;
  logic [7:0] requester = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  logic [2:0] status;
  logic       send_revoke;
  logic       send_retry;
  logic [7:0] notify_client;

  // predicted lock table
  logic       tbl_valid   [NUM_LOCKS];
  logic [1:0] tbl_mode    [NUM_LOCKS];
  client_t    tbl_owner   [NUM_LOCKS];
  client_t    tbl_waiters [NUM_LOCKS][WAIT_DEPTH];
  wait_ptr_t  tbl_head    [NUM_LOCKS];
  wait_cnt_t  tbl_count   [NUM_LOCKS];

  lock_reply_t lock_reply_q[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int unsigned rsp_stall_left = 0;
  logic        req_no_gap = 1'b0;
  logic        rsp_no_stall = 1'b0;

  lock_manager_with_waiter_queues u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .cmd          (cmd),
    .lock_id      (lock_id),
    .requester    (requester),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .send_revoke  (send_revoke),
    .send_retry   (send_retry),
    .notify_client(notify_client)
  );

  initial forever #5 clk = ~clk;

  function automatic void add_waiter(input lock_idx_t lk, input client_t who);
    wait_ptr_t slot;
    slot = wait_ptr_t'((int'(tbl_head[lk]) + int'(tbl_count[lk])) % WAIT_DEPTH);
    tbl_waiters[lk][slot] = who;
    tbl_count[lk] = tbl_count[lk] + 1'b1;
  endfunction

  function automatic lock_reply_t predict_lock_reply(input logic op, input lock_idx_t lk,
                                                     input client_t who);
    lock_reply_t r;
    logic [1:0]  mode;
    logic        at_head;
    logic        full;
    r = '0;
    r.status = ST_OK;
    if (int'(lk) >= NUM_LOCKS) begin
      r.status = ST_NOENT;
    end else begin
      mode = tbl_valid[lk] ? tbl_mode[lk] : MODE_FREE;
      full = int'(tbl_count[lk]) >= WAIT_DEPTH;
      at_head = (mode == MODE_RETRY) && (tbl_count[lk] != 0) &&
                (tbl_waiters[lk][tbl_head[lk]] == who);
      if (op == CMD_ACQUIRE) begin
        if (mode != MODE_FREE && !at_head && full) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[lk] = 1'b1;
          case (mode)
            MODE_FREE: begin
              tbl_owner[lk] = who;
              tbl_mode[lk] = MODE_LOCKED;
            end
            MODE_LOCKED: begin
              add_waiter(lk, who);
              tbl_mode[lk] = MODE_WAITED;
              r.status = ST_RETRY;
              r.revoke = 1'b1;
              r.notify = tbl_owner[lk];
            end
            MODE_WAITED: begin
              add_waiter(lk, who);
              r.status = ST_RETRY;
            end
            default: begin
              if (at_head) begin
                tbl_head[lk] = wait_ptr_t'((int'(tbl_head[lk]) + 1) % WAIT_DEPTH);
                tbl_count[lk] = tbl_count[lk] - 1'b1;
                tbl_owner[lk] = who;
                if (tbl_count[lk] != 0) begin
                  tbl_mode[lk] = MODE_WAITED;
                  r.revoke = 1'b1;
                  r.notify = who;
                end else begin
                  tbl_mode[lk] = MODE_LOCKED;
                end
              end else begin
                add_waiter(lk, who);
                r.status = ST_RETRY;
              end
            end
          endcase
        end
      end else begin
        if (!tbl_valid[lk]) begin
          r.status = ST_NOENT;
        end else if (mode == MODE_LOCKED) begin
          tbl_mode[lk] = MODE_FREE;
        end else if (mode == MODE_WAITED) begin
          tbl_mode[lk] = MODE_RETRY;
          r.retry = 1'b1;
          r.notify = tbl_waiters[lk][tbl_head[lk]];
        end else begin
          r.status = ST_IOERR;
        end
      end
    end
    return r;
  endfunction

  // one request transaction, starting at the edge of the previous acceptance
  task automatic send_request(input logic op, input lock_idx_t lk, input client_t who);
    int unsigned gap;
    lock_reply_t want;
    gap = req_no_gap ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 31) == 0) req_no_gap = !req_no_gap;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= op;
    lock_id <= lk;
    requester <= who;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = predict_lock_reply(op, lk, who);
    lock_reply_q.insert(lock_reply_q.size(), want);
  endtask

  task automatic test_release_unknown();
    send_request(CMD_RELEASE, 6'd5, 8'd0);
  endtask

  task automatic test_grant_free();
    send_request(CMD_ACQUIRE, 6'd0, 8'd0);
    send_request(CMD_RELEASE, 6'd0, 8'd255);  // owner not checked
    send_request(CMD_RELEASE, 6'd0, 8'd0);    // io error on a free lock
  endtask

  task automatic test_revoke_retry();
    send_request(CMD_ACQUIRE, 6'd63, 8'd255);
    send_request(CMD_ACQUIRE, 6'd63, 8'd1);   // revoke to owner
    send_request(CMD_ACQUIRE, 6'd63, 8'd2);
    send_request(CMD_RELEASE, 6'd63, 8'd255); // retry to head waiter
    send_request(CMD_RELEASE, 6'd63, 8'd255); // io error in retry mode
    send_request(CMD_ACQUIRE, 6'd63, 8'd2);   // not the head, queued again
    send_request(CMD_ACQUIRE, 6'd63, 8'd1);   // head takes over, waiters remain
  endtask

  task automatic test_queue_full();
    send_request(CMD_ACQUIRE, 6'd42, 8'd170);
    for (int i = 0; i < WAIT_DEPTH; i++) send_request(CMD_ACQUIRE, 6'd42, client_t'(85 + i));
    send_request(CMD_ACQUIRE, 6'd42, 8'd200); // full while waited
    send_request(CMD_RELEASE, 6'd42, 8'd170);
    send_request(CMD_ACQUIRE, 6'd42, 8'd201); // full while retry
    send_request(CMD_ACQUIRE, 6'd42, 8'd85);  // head still gets it
  endtask

  // mostly protocol-shaped traffic on a few hot locks, some raw noise
  task automatic test_random_traffic(input int unsigned n_items);
    lock_idx_t   hot  [4];
    client_t     pool [12];
    lock_idx_t   lk;
    client_t     who;
    logic        op;
    logic [1:0]  mode;
    int unsigned pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        foreach (hot[k]) hot[k] = lock_idx_t'($urandom_range(0, NUM_LOCKS - 1));
        foreach (pool[k]) pool[k] = client_t'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 15) begin
        op = 1'($urandom_range(0, 1));
        lk = lock_idx_t'($urandom_range(0, NUM_LOCKS - 1));
        who = client_t'($urandom_range(0, 255));
      end else begin
        lk = hot[2'($urandom_range(0, 3))];
        who = pool[4'($urandom_range(0, 11))];
        pick = $urandom_range(0, 99);
        mode = tbl_valid[lk] ? tbl_mode[lk] : MODE_FREE;
        case (mode) inside
          MODE_FREE: op = (pick < 85) ? CMD_ACQUIRE : CMD_RELEASE;
          MODE_LOCKED, MODE_WAITED: op = (pick < 35) ? CMD_RELEASE : CMD_ACQUIRE;
          default: begin
            op = (pick < 15) ? CMD_RELEASE : CMD_ACQUIRE;
            if (pick < 75 && tbl_count[lk] != 0) who = tbl_waiters[lk][tbl_head[lk]];
          end
        endcase
      end
      send_request(op, lk, who);
    end
  endtask

  // response side stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_stall_left <= $urandom_range(0, 3);
    end else if (rsp_valid && rsp_ready) begin
      if ($urandom_range(0, 31) == 0) rsp_no_stall <= !rsp_no_stall;
      if (!rsp_no_stall && $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b0;
        rsp_stall_left <= $urandom_range(1, 3);
      end
    end else if (!rsp_ready) begin
      if (rsp_stall_left <= 1) rsp_ready <= 1'b1;
      else rsp_stall_left <= rsp_stall_left - 1;
    end
  end

  // response transaction checker
  always @(posedge clk) begin
    lock_reply_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (lock_reply_q.size() == 0) begin
        $display("%0t: unexpected response status %0d", $time, status);
        fail_count++;
      end else begin
        want = lock_reply_q[0];
        lock_reply_q.delete(0);
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          fail_count++;
        end
        if (send_revoke !== want.revoke) begin
          $display("%0t: send_revoke expected %0b actual %0b", $time, want.revoke, send_revoke);
          fail_count++;
        end
        if (send_retry !== want.retry) begin
          $display("%0t: send_retry expected %0b actual %0b", $time, want.retry, send_retry);
          fail_count++;
        end
        if (notify_client !== want.notify) begin
          $display("%0t: notify_client expected %0d actual %0d", $time, want.notify,
                   notify_client);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_mode[i] = MODE_FREE;
      tbl_head[i] = '0;
      tbl_count[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_release_unknown();
    test_grant_free();
    test_revoke_retry();
    test_queue_full();
    test_random_traffic(RANDOM_ITEMS);
    req_valid <= 1'b0;
    while (lock_reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
